/* rtl/spq_pkg.sv */
// spq_pkg: shared constants, codes and types of the sorted priority queue.
// Used by the channel interfaces, the queue cell and the top level.
`default_nettype none

package spq_pkg;

  // Default configuration
  localparam int DEPTH_DEF          = 16;
  localparam int VALUE_WIDTH_DEF    = 16;
  localparam int PRIORITY_WIDTH_DEF = 16;

  // Fixed field widths on the channels
  localparam int ITEM_W   = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Command codes
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic insert;   // accepted insert that fits
    logic extract;  // accepted extract on a non-empty queue
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/spq_in_if.sv */
// spq_in_if: request channel of the queue (valid/ready plus command word).
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [ITEM_W-1:0] item_value;
  logic [ITEM_W-1:0] item_priority;

  modport source (output valid, command, item_value, item_priority, input ready);
  modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

`default_nettype wire

/* rtl/spq_out_if.sv */
// spq_out_if: result channel of the queue (valid/ready plus result word).
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_out_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ITEM_W-1:0]   out_value;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, out_value, status, occupancy, input ready);
  modport sink   (input valid, out_value, status, occupancy, output ready);
endinterface

`default_nettype wire

/* rtl/spq_cell.sv */
// spq_cell: one slot of the sorted chain; holds one priority/value pair.
// Depends on spq_pkg (cell_ctl_t). Instantiated DEPTH times by the top level.
`default_nettype none

module spq_cell import spq_pkg::*; #(
  parameter int INDEX          = 0,
  parameter int DEPTH          = DEPTH_DEF,
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
  localparam int CW            = $clog2(DEPTH + 1)
) (
  input  wire                       clk,
  input  wire  cell_ctl_t           ctl,
  input  wire  [CW-1:0]             count,
  input  wire  [PRIORITY_WIDTH-1:0] new_pri,
  input  wire  [VALUE_WIDTH-1:0]    new_val,
  input  wire                       left_take,
  input  wire  [PRIORITY_WIDTH-1:0] left_pri,
  input  wire  [VALUE_WIDTH-1:0]    left_val,
  input  wire  [PRIORITY_WIDTH-1:0] right_pri,
  input  wire  [VALUE_WIDTH-1:0]    right_val,
  output logic                      take,
  output logic [PRIORITY_WIDTH-1:0] pri,
  output logic [VALUE_WIDTH-1:0]    val
);

  logic occupied;

  // Slot is live when it lies below the fill count.
  assign occupied = CW'(INDEX) < count;
  // New word belongs here or further left: empty slot, or key not above ours.
  assign take = !occupied || (new_pri <= pri);

  always_ff @(posedge clk) begin
    if (ctl.insert && take) begin
      if (left_take) begin
        pri <= left_pri;
        val <= left_val;
      end else begin
        pri <= new_pri;
        val <= new_val;
      end
    end else if (ctl.extract) begin
      pri <= right_pri;
      val <= right_val;
    end
  end

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// sorted_priority_queue: bounded priority queue built as a chain of sorting cells.
// Depends on spq_pkg, spq_in_if, spq_out_if and spq_cell.
//
//   channel  dir  handshake     word
//   -------  ---  ------------  ---------------------------------------
//   req      in   valid/ready   command, item_value, item_priority
//   rsp      out  valid/ready   out_value, status, occupancy
//
// Every cell compares the incoming key and shifts in the same cycle, so a
// request is accepted each cycle while rsp is drained.
// The result lands in an output register in the cycle after acceptance.
// req.ready is high while the output register is empty or being taken, so a
// stalled rsp holds its word and blocks only further requests.
// Synchronous reset empties the queue (fill count zero); cell contents stay.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH          = DEPTH_DEF,
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input wire          clk,
  input wire          rst,
  spq_in_if.sink      req,
  spq_out_if.source   rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  // Fill count: slots [0, count) hold live entries in ascending key order.
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Output register
  logic              rsp_valid;
  logic [ITEM_W-1:0] rsp_value;
  status_t           rsp_status;
  logic [OCC_W-1:0]  rsp_occupancy;

  logic      fire;
  logic      full;
  logic      empty;
  cell_ctl_t ctl;
  status_t   status_next;
  logic [ITEM_W-1:0] value_next;

  // Incoming word resized to the stored widths
  logic [63:0]               val_ext;
  logic [31:0]               pri_ext;
  logic [VALUE_WIDTH-1:0]    new_val;
  logic [PRIORITY_WIDTH-1:0] new_pri;
  logic [63:0]               front_ext;
  logic [31:0]               count_ext;

  // Chain wiring
  logic                      take [DEPTH];
  logic [PRIORITY_WIDTH-1:0] pri  [DEPTH];
  logic [VALUE_WIDTH-1:0]    val  [DEPTH];

  assign val_ext = 64'(req.item_value);
  assign pri_ext = 32'(req.item_priority);
  assign new_val = val_ext[VALUE_WIDTH-1:0];
  assign new_pri = pri_ext[PRIORITY_WIDTH-1:0];

  assign req.ready = !rsp_valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign full      = count == CW'(DEPTH);
  assign empty     = count == '0;

  assign ctl.insert  = fire && (req.command == CMD_INSERT) && !full;
  assign ctl.extract = fire && (req.command == CMD_EXTRACT) && !empty;

  // Front cell holds the smallest key.
  assign front_ext = 64'(val[0]);

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    value_next  = '0;
    if (req.command == CMD_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        count_next = count - 1'b1;
        value_next = front_ext[ITEM_W-1:0];
      end
    end
  end

  assign count_ext = 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_value     <= value_next;
      rsp_status    <= status_next;
      rsp_occupancy <= count_ext[OCC_W-1:0];
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.out_value = rsp_value;
  assign rsp.status    = rsp_status;
  assign rsp.occupancy = rsp_occupancy;

  // The chain: each cell looks left on insert (shift right) and right on
  // extract (shift toward the front).
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      lt;
    logic [PRIORITY_WIDTH-1:0] lp;
    logic [VALUE_WIDTH-1:0]    lv;
    logic [PRIORITY_WIDTH-1:0] rp;
    logic [VALUE_WIDTH-1:0]    rv;

    if (i == 0) begin : g_head
      assign lt = 1'b0;
      assign lp = '0;
      assign lv = '0;
    end else begin : g_mid
      assign lt = take[i-1];
      assign lp = pri[i-1];
      assign lv = val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rp = '0;
      assign rv = '0;
    end else begin : g_body
      assign rp = pri[i+1];
      assign rv = val[i+1];
    end

    spq_cell #(
      .INDEX          (i),
      .DEPTH          (DEPTH),
      .VALUE_WIDTH    (VALUE_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .new_pri   (new_pri),
      .new_val   (new_val),
      .left_take (lt),
      .left_pri  (lp),
      .left_val  (lv),
      .right_pri (rp),
      .right_val (rv),
      .take      (take[i]),
      .pri       (pri[i]),
      .val       (val[i])
    );
  end

endmodule

`default_nettype wire
